// ===== design/ibmdk_pkg.sv =====
// Package for the delta kernel weight unit: kernel selection codes, shared
// types and the pipeline depth helper. No dependencies.
package ibmdk_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int CFG_AW        = 3;
  localparam logic [CFG_AW-1:0] ADDR_KERNEL_SUPPORT = 3'd0;

  typedef enum logic [1:0] {
    KERN_HAT = 2'd0,
    KERN_P3  = 2'd1,
    KERN_P4  = 2'd2
  } kern_t;

  // Travels alongside the arithmetic of one axis.
  typedef struct packed {
    logic [16:0] mag;
    kern_t       kern;
    logic        piece;
    logic        zero;
  } side_t;

  // Root stages: one result bit per stage of a radicand of 2*frac+2 bits.
  function automatic int sqrt_stages(input int frac);
    return frac + 1;
  endfunction

endpackage

// ===== design/ibmdk_axis.sv =====
// One-axis kernel evaluation: magnitude, radicand, bit-per-stage square root,
// numerator and scaling to Q1.15. Depends on ibmdk_pkg.
module ibmdk_axis #(
  parameter int FRAC_BITS = ibmdk_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  axis_d,
  input  ibmdk_pkg::kern_t    kern,
  output logic        [15:0]  axis_w
);
  import ibmdk_pkg::*;

  localparam int NS   = sqrt_stages(FRAC_BITS);
  localparam int RADW = 2 * FRAC_BITS + 2;
  localparam int RSW  = 2 * FRAC_BITS + 20;
  localparam int NW   = FRAC_BITS + 5;
  localparam int TW   = FRAC_BITS + 21;
  localparam logic signed [RSW-1:0] S  = RSW'(1) <<< FRAC_BITS;
  localparam logic signed [RSW-1:0] S2 = RSW'(1) <<< (2 * FRAC_BITS);
  localparam logic [17:0] U3_MAX = 18'd98304;
  localparam logic [17:0] Q_MAX  = 18'd32768;
  localparam logic [17:0] RECIP3 = 18'd174763;

  // Stage A: magnitude.
  side_t a_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_r.mag   <= axis_d[15] ? 17'(-{axis_d[15], axis_d}) : {1'b0, axis_d};
      a_r.kern  <= kern;
      a_r.piece <= 1'b0;
      a_r.zero  <= 1'b0;
    end
  end

  // Stage B: square of the magnitude and piece selection.
  side_t b_r;
  logic [33:0] aa_r;
  logic signed [RSW-1:0] am;
  logic piece_nxt, zero_nxt;
  always_comb begin
    am = RSW'(a_r.mag);
    piece_nxt = 1'b0;
    zero_nxt  = 1'b0;
    case (a_r.kern)
      KERN_HAT: begin
        zero_nxt = am >= S;
      end
      KERN_P3: begin
        piece_nxt = (am <<< 1) >= S;
        zero_nxt  = (am <<< 1) >= 3 * S;
      end
      default: begin
        piece_nxt = am >= S;
        zero_nxt  = am >= (S <<< 1);
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (en) begin
      aa_r <= a_r.mag * a_r.mag;
      b_r  <= {a_r.mag, a_r.kern, piece_nxt, zero_nxt};
    end
  end

  // Stage C: radicand, negative values taken as zero.
  side_t c_r;
  logic [RADW-1:0] rad_r;
  logic signed [RSW-1:0] poly, aas, as;
  always_comb begin
    aas = RSW'(aa_r);
    as  = RSW'(b_r.mag) <<< FRAC_BITS;
    case (b_r.kern)
      KERN_P3: poly = b_r.piece ? (-2 * S2 + 6 * as - 3 * aas) : (S2 - 3 * aas);
      KERN_P4: poly = b_r.piece ? (-7 * S2 + 12 * as - 4 * aas)
                                : (S2 + 4 * as - 4 * aas);
      default: poly = '0;
    endcase
    if (poly < 0 || b_r.zero) poly = '0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= poly[RADW-1:0];
      c_r   <= b_r;
    end
  end

  // Square root, one result bit per stage.
  logic [RADW-1:0] rem_q [NS+1];
  logic [RADW-1:0] res_q [NS+1];
  side_t           sd_q  [NS+1];
  assign rem_q[0] = rad_r;
  assign res_q[0] = '0;
  assign sd_q[0]  = c_r;

  for (genvar j = 0; j < NS; j++) begin : g_root
    localparam logic [RADW-1:0] BIT = RADW'(1) << (2 * (NS - 1 - j));
    logic [RADW-1:0] rem_nxt, res_nxt, rem_r, res_r;
    side_t sd_r;
    always_comb begin
      if (rem_q[j] >= res_q[j] + BIT) begin
        rem_nxt = rem_q[j] - (res_q[j] + BIT);
        res_nxt = (res_q[j] >> 1) + BIT;
      end else begin
        rem_nxt = rem_q[j];
        res_nxt = res_q[j] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_nxt;
        res_r <= res_nxt;
        sd_r  <= sd_q[j];
      end
    end
    assign rem_q[j+1] = rem_r;
    assign res_q[j+1] = res_r;
    assign sd_q[j+1]  = sd_r;
  end

  // Stage N: numerator, clamped at zero, and the divisor class.
  typedef enum logic [1:0] {DIV_1 = 2'd0, DIV_3 = 2'd1, DIV_6 = 2'd2, DIV_8 = 2'd3} div_t;
  side_t sdn;
  logic signed [NW-1:0] num, sn, an, rt;
  div_t dv_nxt, n_dv_r;
  logic [NW-2:0] num_r;
  always_comb begin
    sdn = sd_q[NS];
    sn  = NW'(1) <<< FRAC_BITS;
    an  = NW'(sdn.mag);
    rt  = NW'(res_q[NS][FRAC_BITS:0]);
    case (sdn.kern)
      KERN_HAT: begin
        num = sn - an;
        dv_nxt = DIV_1;
      end
      KERN_P3: begin
        num    = sdn.piece ? (5 * sn - 3 * an - rt) : (sn + rt);
        dv_nxt = sdn.piece ? DIV_6 : DIV_3;
      end
      default: begin
        num    = sdn.piece ? (5 * sn - 2 * an - rt) : (3 * sn - 2 * an + rt);
        dv_nxt = DIV_8;
      end
    endcase
    if (num < 0 || sdn.zero) num = '0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num[NW-2:0];
      n_dv_r <= dv_nxt;
    end
  end

  // Stage D: scale by the power-of-two part of k*S with rounding.
  logic [TW-1:0] t;
  logic [17:0] u, u_r;
  logic div3_r;
  localparam logic [TW-1:0] HALF_S = TW'(1) << (FRAC_BITS - 1);
  always_comb begin
    t = TW'(num_r) << 15;
    case (n_dv_r)
      DIV_1: begin t = t + HALF_S;     u = 18'(t >> FRAC_BITS);       end
      DIV_3: begin t = t + 3 * HALF_S; u = 18'(t >> FRAC_BITS);       end
      DIV_6: begin t = t + 6 * HALF_S; u = 18'(t >> (FRAC_BITS + 1)); end
      default: begin t = t + 8 * HALF_S; u = 18'(t >> (FRAC_BITS + 3)); end
    endcase
    if (n_dv_r == DIV_3 || n_dv_r == DIV_6) begin
      if (u > U3_MAX) u = U3_MAX;
    end else if (u > Q_MAX) begin
      u = Q_MAX;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= u;
      div3_r <= (n_dv_r == DIV_3) || (n_dv_r == DIV_6);
    end
  end

  // Stage E: division by three through the reciprocal; exact below 2^19.
  logic [35:0] p_r;
  logic div3_e_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_r      <= div3_r ? (u_r * RECIP3) : 36'(u_r);
      div3_e_r <= div3_r;
    end
  end

  // Stage F: final axis weight.
  logic [15:0] w_r;
  always_ff @(posedge clk) begin
    if (en) w_r <= div3_e_r ? 16'(p_r >> 19) : 16'(p_r);
  end
  assign axis_w = w_r;

endmodule

// ===== design/ibm_delta_kernel_weight_unit.sv =====
// Discrete delta weight unit: three axis kernels and their product.
// Its depth is set by the FRAC_BITS + 1 square-root stages, one bit each;
// throughput one transaction per cycle, the whole pipe holds on stall.
// Reset (rst_n, synchronous) clears the valid bits and sets kernel_support to 4.
// Depends on ibmdk_pkg and ibmdk_axis.
module ibm_delta_kernel_weight_unit #(
  parameter int FRAC_BITS = ibmdk_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_dist_x,
  input  logic signed [15:0]            in_dist_y,
  input  logic signed [15:0]            in_dist_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic        [15:0]            out_weight,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ibmdk_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import ibmdk_pkg::*;

  localparam int AXL = sqrt_stages(FRAC_BITS) + 7;
  localparam int L   = AXL + 3;

  logic [2:0] ksup_r;
  logic en;
  kern_t kern;
  logic [L-1:0] vld_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_KERNEL_SUPPORT) ? {29'd0, ksup_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksup_r <= 3'd4;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == ADDR_KERNEL_SUPPORT) begin
      ksup_r <= cfg_pwdata[2:0];
    end
  end

  always_comb begin
    case (ksup_r)
      3'd2:    kern = KERN_HAT;
      3'd3:    kern = KERN_P3;
      default: kern = KERN_P4;
    endcase
  end

  // The pipe moves unless a finished transaction is held at the output.
  assign en       = !(vld_r[L-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_valid};
    end
  end

  logic [15:0] wx, wy, wz;
  ibmdk_axis #(.FRAC_BITS(FRAC_BITS)) u_ax (.clk, .en, .axis_d(in_dist_x), .kern, .axis_w(wx));
  ibmdk_axis #(.FRAC_BITS(FRAC_BITS)) u_ay (.clk, .en, .axis_d(in_dist_y), .kern, .axis_w(wy));
  ibmdk_axis #(.FRAC_BITS(FRAC_BITS)) u_az (.clk, .en, .axis_d(in_dist_z), .kern, .axis_w(wz));

  logic [31:0] m1_r;
  logic [15:0] wz_r;
  logic [32:0] m2_r;
  logic [15:0] w_r;
  logic [16:0] p1;
  always_comb p1 = 17'((33'(m1_r) + 33'd16384) >> 15);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= wx * wy;
      wz_r <= wz;
      m2_r <= p1 * wz_r;
      w_r  <= 16'((34'(m2_r) + 34'd16384) >> 15);
    end
  end

  assign out_valid  = vld_r[L-1];
  assign out_weight = w_r;

endmodule

// ===== sim/tb_ibm_delta_kernel_weight_unit.sv =====
// Self-checking testbench for the delta kernel weight unit: a fixed-point
// predictor of the three-axis kernel product checks every weight in order.
// Depends on ibmdk_pkg and the unit under test.
module tb_ibm_delta_kernel_weight_unit;
  import ibmdk_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int SC = 1 << FB;
  localparam int SUP_HAT = 2;
  localparam int SUP_P3 = 3;
  localparam int SUP_P4 = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_dist_x = '0, in_dist_y = '0, in_dist_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_weight;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  int errors = 0;
  bit quiet = 1'b0;

  ibm_delta_kernel_weight_unit dut (.*);

  always #4 clk = ~clk;

  function automatic longint floor_root(longint v);
    longint r = 0;
    longint b = 64'sd1 <<< 40;
    longint x = v;
    if (v <= 0) return 0;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - r - b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint q15_of(longint num, longint k);
    longint den = k * SC;
    longint q;
    if (num <= 0) return 0;
    q = ((num <<< 15) + den / 2) / den;
    return (q > 32768) ? 32768 : q;
  endfunction

  function automatic longint axis_kernel(logic [15:0] d, logic [2:0] sup);
    longint a = d[15] ? (65536 - longint'(d)) : longint'(d);
    longint s = SC;
    if (sup == SUP_HAT) return (a < s) ? q15_of(s - a, 1) : 0;
    if (sup == SUP_P3) begin
      if (2 * a < s) return q15_of(s + floor_root(s * s - 3 * a * a), 3);
      if (2 * a < 3 * s)
        return q15_of(5 * s - 3 * a - floor_root(-2 * s * s + 6 * a * s - 3 * a * a), 6);
      return 0;
    end
    if (a < s) return q15_of(3 * s - 2 * a + floor_root(s * s + 4 * a * s - 4 * a * a), 8);
    if (a < 2 * s)
      return q15_of(5 * s - 2 * a - floor_root(-7 * s * s + 12 * a * s - 4 * a * a), 8);
    return 0;
  endfunction

  class weight_scoreboard;
    logic [2:0] support = 3'd4;
    logic [15:0] pending[$];

    function void note_distance(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      longint wx = axis_kernel(x, support);
      longint wy = axis_kernel(y, support);
      longint wz = axis_kernel(z, support);
      longint p = (wx * wy + (1 << 14)) >>> 15;
      p = (p * wz + (1 << 14)) >>> 15;
      pending.push_back(p[15:0]);
    endfunction

    function void check_weight(logic [15:0] w);
      logic [15:0] e;
      if (pending.size() == 0) begin
        $error("unexpected weight transaction %0d", w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e !== w) begin
        $error("weight: expected %0d, actual %0d", e, w);
        errors++;
      end
    endfunction
  endclass

  weight_scoreboard sb = new();

  // Monitor: both handshakes sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_distance(in_dist_x, in_dist_y, in_dist_z);
    if (rst_n && out_valid && !out_stall) sb.check_weight(out_weight);
  end

  // Receiver back-pressure in random bursts.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic write_support(logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= ADDR_KERNEL_SUPPORT;
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.support = v[2:0];
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Valid stays high between back-to-back transactions and drops only for idling.
  task automatic send_distance(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int n;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_dist_x <= x; in_dist_y <= y; in_dist_z <= z;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (FB + 16) @(posedge clk);
  endtask

  // Mostly distances within the support, a share anywhere in the range.
  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2: return 16'($signed($urandom_range(0, 2)) * (SC / 2) * ($urandom_range(0, 1) ? 1 : -1));
      default: return 16'(int'($urandom_range(0, 4 * SC)) - 2 * SC);
    endcase
  endfunction

  initial begin
    logic [15:0] edges[$] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                              16'(SC / 2), 16'(-SC / 2), 16'(SC), 16'(-SC),
                              16'(3 * SC / 2), 16'(2 * SC), 16'(2 * SC - 1)};
    int sups[$] = '{SUP_P3, SUP_HAT, 7, 0, SUP_P4};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (sups[k]) begin
      write_support(sups[k]);
      if (k < 3)
        foreach (edges[i]) send_distance(edges[i], edges[(i + 3) % 12], edges[(i + 7) % 12]);
      repeat (150) begin
        if (k == 4) quiet = 1'b1;
        send_distance(pick_distance(), pick_distance(), pick_distance());
      end
      drain();
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/ibmdk_pkg.sv
design/ibmdk_axis.sv
design/ibm_delta_kernel_weight_unit.sv
sim/tb_ibm_delta_kernel_weight_unit.sv
